// ----- rtl/mbe_pkg.sv -----
// ----------------------------------------------------------------------------
// Multipart boundary extractor package
// Shared sizes, codes, item types and the control bundle for the match cells.
// ----------------------------------------------------------------------------
package mbe_pkg;

  localparam int MAX_VALUE_LEN = 70;
  localparam int WINDOW_DEPTH  = 74;

  localparam int IDX_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int VLEN_W = $clog2(MAX_VALUE_LEN + 1);
  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int CMP_W  = $clog2(MAX_VALUE_LEN + WINDOW_DEPTH + 5);
  localparam int CNT_W  = 24;

  localparam int HDR_LEN   = 4;
  localparam int DASH_LEN  = 2;
  localparam int DATA_XTRA = 4;

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_BODY   = 2'd2;
  localparam logic [1:0] OP_END    = 2'd3;

  localparam logic [1:0] PH_BEGIN  = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_DATA   = 2'd2;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_REPORT  = 1'b1;

  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_DASH = 8'h2D;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic             kind;
    logic [7:0]       payload_byte;
    logic             first_of_file;
    logic [CNT_W-1:0] byte_count;
    logic             upload_ok;
  } out_item_t;

  typedef struct packed {
    logic              win_shift;
    logic              val_shift;
    logic [1:0]        phase;
    logic [VLEN_W-1:0] vlen;
  } cell_ctl_t;

endpackage

// ----- rtl/multipart_boundary_extractor.sv -----
// ----------------------------------------------------------------------------
// Multipart boundary extractor
// Results are registered: each appears in the cycle after its transaction.
// Throughput: one transaction per unstalled cycle, set by the combinational
// compare across the row of match cells and the one-entry output register.
// Reset clears phase, lengths, fill and count; cell bytes are not reset.
// ----------------------------------------------------------------------------
module multipart_boundary_extractor
  import mbe_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic [VLEN_W-1:0] vlen_r;
  logic [VLEN_W-1:0] vlen_nxt;
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;
  logic [1:0]        phase_r;
  logic [1:0]        phase_nxt;
  logic [CNT_W-1:0]  total_r;
  logic [CNT_W-1:0]  total_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  out_item_t         out_data_r;
  out_item_t         out_data_nxt;

  logic              acc;
  logic              out_take;
  cell_ctl_t         ctl;
  logic [7:0]        win_chain [WINDOW_DEPTH];
  logic [7:0]        val_chain [WINDOW_DEPTH];
  logic [7:0]        taps      [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] hits;
  logic [7:0]        tap_or;
  logic              hit_all;
  logic [CMP_W-1:0]  plen;
  logic [FILL_W-1:0] fill_after;
  logic              full;
  logic              emit;

  assign in_stall = out_valid_r && out_stall;
  assign acc      = in_valid && !in_stall;
  assign out_take = out_valid_r && !out_stall;

  assign ctl.win_shift = acc && (in_data.op == OP_BODY);
  assign ctl.val_shift = acc && (in_data.op == OP_APPEND) &&
                         (vlen_r < VLEN_W'(MAX_VALUE_LEN));
  assign ctl.phase     = phase_r;
  assign ctl.vlen      = vlen_r;

  for (genvar g = 0; g < WINDOW_DEPTH; g++) begin : g_cell
    logic [7:0] win_src;
    logic [7:0] val_src;
    if (g == 0) begin : g_head
      assign win_src = in_data.data_byte;
      assign val_src = in_data.data_byte;
    end else begin : g_body
      assign win_src = win_chain[g-1];
      assign val_src = val_chain[g-1];
    end
    mbe_cell u_cell (
      .clk     (clk),
      .idx     (IDX_W'(g)),
      .ctl     (ctl),
      .win_in  (win_src),
      .val_in  (val_src),
      .win_out (win_chain[g]),
      .val_out (val_chain[g]),
      .hit     (hits[g]),
      .tap     (taps[g])
    );
  end

  assign hit_all = &hits;

  always_comb begin
    tap_or = 8'h00;
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      tap_or = tap_or | taps[i];
    end
  end

  always_comb begin
    case (phase_r)
      PH_HEADER: plen = CMP_W'(HDR_LEN);
      PH_DATA:   plen = CMP_W'(vlen_r) + CMP_W'(DATA_XTRA);
      default:   plen = CMP_W'(vlen_r) + CMP_W'(DASH_LEN);
    endcase
  end

  assign fill_after = (fill_r == FILL_W'(WINDOW_DEPTH)) ? fill_r : fill_r + FILL_W'(1);
  assign full       = CMP_W'(fill_after) >= plen;

  always_comb begin
    vlen_nxt      = vlen_r;
    fill_nxt      = fill_r;
    phase_nxt     = phase_r;
    total_nxt     = total_r;
    emit          = 1'b0;
    out_data_nxt  = out_data_r;
    if (acc) begin
      case (in_data.op)
        OP_START: begin
          vlen_nxt  = '0;
          fill_nxt  = '0;
          phase_nxt = PH_BEGIN;
          total_nxt = '0;
        end
        OP_APPEND: begin
          if (vlen_r < VLEN_W'(MAX_VALUE_LEN)) begin
            vlen_nxt = vlen_r + VLEN_W'(1);
          end
        end
        OP_BODY: begin
          fill_nxt = fill_after;
          if (full) begin
            if (hit_all) begin
              fill_nxt  = '0;
              phase_nxt = (phase_r == PH_HEADER) ? PH_DATA : PH_HEADER;
            end else begin
              fill_nxt = fill_after - FILL_W'(1);
              if (phase_r == PH_DATA) begin
                emit      = 1'b1;
                total_nxt = (total_r == COUNT_MAX) ? total_r : total_r + CNT_W'(1);
                out_data_nxt.kind          = KIND_PAYLOAD;
                out_data_nxt.payload_byte  = tap_or;
                out_data_nxt.first_of_file = (total_r == '0);
                out_data_nxt.byte_count    = total_nxt;
                out_data_nxt.upload_ok     = 1'b0;
              end
            end
          end
        end
        default: begin
          emit = 1'b1;
          out_data_nxt.kind          = KIND_REPORT;
          out_data_nxt.payload_byte  = 8'h00;
          out_data_nxt.first_of_file = 1'b0;
          out_data_nxt.byte_count    = total_r;
          out_data_nxt.upload_ok     = (total_r != '0);
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vlen_r      <= '0;
      fill_r      <= '0;
      phase_r     <= PH_BEGIN;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vlen_r      <= vlen_nxt;
      fill_r      <= fill_nxt;
      phase_r     <= phase_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/mbe_cell.sv -----
// ----------------------------------------------------------------------------
// Multipart boundary extractor match cell
// Holds one window byte and one boundary byte, shifts both along the row and
// compares the incoming window byte with the pattern byte for its position.
// ----------------------------------------------------------------------------
module mbe_cell
  import mbe_pkg::*;
(
  input  logic             clk,
  input  logic [IDX_W-1:0] idx,
  input  cell_ctl_t        ctl,
  input  logic [7:0]       win_in,
  input  logic [7:0]       val_in,
  output logic [7:0]       win_out,
  output logic [7:0]       val_out,
  output logic             hit,
  output logic [7:0]       tap
);

  logic [7:0]       win_r;
  logic [7:0]       win_nxt;
  logic [7:0]       val_r;
  logic [7:0]       val_nxt;
  logic [CMP_W-1:0] pos;
  logic [CMP_W-1:0] len;
  logic [7:0]       exp_byte;
  logic             in_range;

  assign pos = CMP_W'(idx);
  assign len = CMP_W'(ctl.vlen);

  always_comb begin
    exp_byte = CHAR_DASH;
    in_range = 1'b0;
    case (ctl.phase)
      PH_HEADER: begin
        exp_byte = idx[0] ? CHAR_CR : CHAR_LF;
        in_range = pos < CMP_W'(HDR_LEN);
      end
      PH_DATA: begin
        if (pos < len) begin
          exp_byte = val_r;
        end else if (pos == len + CMP_W'(DASH_LEN)) begin
          exp_byte = CHAR_LF;
        end else if (pos == len + CMP_W'(DASH_LEN + 1)) begin
          exp_byte = CHAR_CR;
        end else begin
          exp_byte = CHAR_DASH;
        end
        in_range = pos < len + CMP_W'(DATA_XTRA);
      end
      default: begin
        exp_byte = (pos < len) ? val_r : CHAR_DASH;
        in_range = pos < len + CMP_W'(DASH_LEN);
      end
    endcase
  end

  assign hit = !in_range || (win_in == exp_byte);
  assign tap = (pos == len + CMP_W'(DATA_XTRA - 1)) ? win_in : 8'h00;

  assign win_nxt = ctl.win_shift ? win_in : win_r;
  assign val_nxt = ctl.val_shift ? val_in : val_r;

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    val_r <= val_nxt;
  end

  assign win_out = win_r;
  assign val_out = val_r;

endmodule

// ----- rtl/mbe_checker.sv -----
// ----------------------------------------------------------------------------
// Multipart boundary extractor checker
// Watches the ports of the extractor over time and is bound to the top level.
// ----------------------------------------------------------------------------
module mbe_checker
  import mbe_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled result transaction changed or vanished.");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("Input stalled while the output register could move.");

  a_end_report: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.op == OP_END |=>
      out_valid && out_data.kind == KIND_REPORT)
    else $error("End transaction did not produce a report.");

  a_start_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.op == OP_START |=> !out_valid)
    else $error("Start transaction produced a result.");

  a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_PAYLOAD |->
      !out_data.upload_ok && out_data.byte_count != '0)
    else $error("Payload result carries a bad count or status.");

endmodule

bind multipart_boundary_extractor mbe_checker u_mbe_checker (.*);
